// ===== src/kecat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecat_pkg: shared types for the k-th earliest active channel time block
// Time and rank types, channel limits and the result record.
// ----------------------------------------------------------------------------
package kecat_pkg;

    localparam int MAX_CH  = 8;
    localparam int TIME_W  = 32;
    localparam int RANK_W  = 3;
    localparam int COUNT_W = RANK_W + 1;

    typedef logic signed [TIME_W-1:0] t_time;
    typedef logic [RANK_W-1:0]        t_rank;
    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [MAX_CH-1:0]        t_mask;

    typedef struct packed {
        logic  found;
        t_time sel_time;
    } t_result;

endpackage

// ===== src/kecat_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecat_select: rank-and-select logic
// Ranks every active channel time against all others in parallel and picks
// the time whose rank equals the configured rank.
// ----------------------------------------------------------------------------
module kecat_select #(
    parameter int CHANNELS = 8
) (
    input  kecat_pkg::t_mask   i_mask,
    input  kecat_pkg::t_time   i_time [CHANNELS],
    input  kecat_pkg::t_rank   i_rank,
    output kecat_pkg::t_result o_result
);

    logic [CHANNELS-1:0] w_active;
    logic [CHANNELS-1:0] w_hit;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_active[i] = i_mask[i];
        end
    end

    always_comb begin
        kecat_pkg::t_count cnt;
        logic              earlier;
        for (int i = 0; i < CHANNELS; i++) begin
            cnt = '0;
            for (int j = 0; j < CHANNELS; j++) begin
                earlier = (i_time[j] < i_time[i]) || ((i_time[j] == i_time[i]) && (j < i));
                if (j != i && w_active[j] && earlier) begin
                    cnt = cnt + kecat_pkg::t_count'(1);
                end
            end
            w_hit[i] = w_active[i] && (cnt == {1'b0, i_rank});
        end
    end

    always_comb begin
        kecat_pkg::t_time acc;
        acc = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (w_hit[i]) begin
                acc = acc | i_time[i];
            end
        end
        o_result.found    = |w_hit;
        o_result.sel_time = acc;
    end

endmodule

// ===== src/kth_earliest_active_channel_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_earliest_active_channel_time: order-statistic select over channel times
// Input channel (i_in_valid / o_in_stall) carries one event: an activity mask
// and one signed Q16.16 time per channel. Output channel (o_out_valid /
// i_out_stall) returns one transaction per event: o_out_found and the time
// at zero-based rank i_cfg_wdata (written with i_cfg_we) among the active
// channel times in ascending order; zero and not found when too few
// channels are active. Mask bits at or above CHANNELS are ignored.
// The input register loads at the edge that accepts the event; the parallel
// compare, rank count and select then feed the result register, which loads
// whenever it is empty or its result is taken. One event is accepted every
// cycle while the output is taken. When the receiver stalls, the result
// register holds and the input register fills; o_in_stall rises once both
// are occupied.
// Reset clears both valid flags and sets the rank to zero.
// ----------------------------------------------------------------------------
module kth_earliest_active_channel_time #(
    parameter int CHANNELS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  kecat_pkg::t_rank        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  kecat_pkg::t_mask        i_active_mask,
    input  kecat_pkg::t_time        i_time_ch0,
    input  kecat_pkg::t_time        i_time_ch1,
    input  kecat_pkg::t_time        i_time_ch2,
    input  kecat_pkg::t_time        i_time_ch3,
    input  kecat_pkg::t_time        i_time_ch4,
    input  kecat_pkg::t_time        i_time_ch5,
    input  kecat_pkg::t_time        i_time_ch6,
    input  kecat_pkg::t_time        i_time_ch7,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_out_found,
    output kecat_pkg::t_time        o_out_selected_time
);

    kecat_pkg::t_time   w_in_time [kecat_pkg::MAX_CH];
    kecat_pkg::t_rank   r_rank;
    logic               r_in_vld;
    kecat_pkg::t_mask   r_mask;
    kecat_pkg::t_time   r_time [CHANNELS];
    logic               r_out_vld;
    kecat_pkg::t_result r_out;
    kecat_pkg::t_result w_res;
    kecat_pkg::t_mask   w_ch_mask;
    logic               w_out_adv;
    logic               w_in_adv;

    assign w_in_time[0] = i_time_ch0;
    assign w_in_time[1] = i_time_ch1;
    assign w_in_time[2] = i_time_ch2;
    assign w_in_time[3] = i_time_ch3;
    assign w_in_time[4] = i_time_ch4;
    assign w_in_time[5] = i_time_ch5;
    assign w_in_time[6] = i_time_ch6;
    assign w_in_time[7] = i_time_ch7;

    always_comb begin
        for (int i = 0; i < kecat_pkg::MAX_CH; i++) begin
            w_ch_mask[i] = (i < CHANNELS);
        end
    end

    assign w_out_adv  = !r_out_vld || !i_out_stall;
    assign w_in_adv   = !r_in_vld || w_out_adv;
    assign o_in_stall = !w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else if (i_cfg_we) begin
            r_rank <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_adv) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_in_valid) begin
            r_mask <= i_active_mask & w_ch_mask;
            for (int i = 0; i < CHANNELS; i++) begin
                r_time[i] <= w_in_time[i];
            end
        end
    end

    kecat_select #(
        .CHANNELS (CHANNELS)
    ) u_select (
        .i_mask   (r_mask),
        .i_time   (r_time),
        .i_rank   (r_rank),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_in_vld) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_out_found         = r_out.found;
    assign o_out_selected_time = r_out.sel_time;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_vld && !r_out_vld)
        else $error("pipeline not empty after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld && i_out_stall)
        else $error("input stalled without a full pipeline");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> w_res.found == ($countones(r_mask) > r_rank))
        else $error("found flag disagrees with active channel count");

    a_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.found |-> r_out.sel_time == '0)
        else $error("nonzero time without a selection");
`endif

endmodule

// ===== tb/sv/tb_kth_earliest_active_channel_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kth_earliest_active_channel_time: self-checking bench for the rank select
// Sends detector events (activity mask plus eight signed Q16.16 times) and
// predicts each result by ranking the active times with channel-index tie
// break. Results are checked in order, field by field. Covers directed
// extremes, ties and too-few-active cases, then random events over every
// rank setting with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
module tb_kth_earliest_active_channel_time;

    localparam int NUM_CH = 8;

    typedef logic [kecat_pkg::MAX_CH-1:0][kecat_pkg::TIME_W-1:0] t_time_vec;

    typedef struct packed {
        kecat_pkg::t_mask mask;
        t_time_vec        times;
    } t_event;

    typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} t_idle;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    kecat_pkg::t_rank   cfg_wdata  = '0;
    logic               in_valid   = 1'b0;
    kecat_pkg::t_mask   drv_mask   = '0;
    kecat_pkg::t_time   drv_time [kecat_pkg::MAX_CH] = '{default: '0};
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               out_found;
    kecat_pkg::t_time   out_time;

    kecat_pkg::t_rank   cur_rank   = '0;
    kecat_pkg::t_result rank_q[$];
    t_idle              in_idle    = IDLE_NONE;
    t_idle              out_idle   = IDLE_NONE;
    int                 errors     = 0;
    int                 sent       = 0;
    int                 checked    = 0;
    int                 found_cnt  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    kth_earliest_active_channel_time #(
        .CHANNELS(NUM_CH)
    ) i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_active_mask       (drv_mask),
        .i_time_ch0          (drv_time[0]),
        .i_time_ch1          (drv_time[1]),
        .i_time_ch2          (drv_time[2]),
        .i_time_ch3          (drv_time[3]),
        .i_time_ch4          (drv_time[4]),
        .i_time_ch5          (drv_time[5]),
        .i_time_ch6          (drv_time[6]),
        .i_time_ch7          (drv_time[7]),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_out_found         (out_found),
        .o_out_selected_time (out_time)
    );

    function automatic kecat_pkg::t_result rank_select(input kecat_pkg::t_mask mask,
                                                       input t_time_vec times,
                                                       input kecat_pkg::t_rank rank);
        kecat_pkg::t_result res;
        kecat_pkg::t_count  pos;
        res = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (mask[i]) begin
                pos = '0;
                for (int j = 0; j < NUM_CH; j++) begin
                    if (j != i && mask[j] &&
                        ($signed(times[j]) < $signed(times[i]) ||
                         (times[j] == times[i] && j < i)))
                        pos++;
                end
                if (pos == {1'b0, rank}) begin
                    res.found    = 1'b1;
                    res.sel_time = times[i];
                end
            end
        end
        return res;
    endfunction

    function automatic int draw_gap(input t_idle mode);
        case (mode)
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            IDLE_FULL:   return $urandom_range(0, 15);
            default:     return 0;
        endcase
    endfunction

    function automatic t_idle draw_idle();
        case ($urandom_range(0, 2))
            0:       return IDLE_NONE;
            1:       return IDLE_SPARSE;
            default: return IDLE_FULL;
        endcase
    endfunction

    function automatic kecat_pkg::t_time edge_time();
        case ($urandom_range(0, 4))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic t_event random_event();
        t_event           ev;
        kecat_pkg::t_time base;
        case ($urandom_range(0, 3))
            0:       ev.mask = kecat_pkg::t_mask'($urandom);
            1:       ev.mask = '1;
            2:       ev.mask = kecat_pkg::t_mask'($urandom & $urandom);
            default: ev.mask = kecat_pkg::t_mask'($urandom | $urandom);
        endcase
        base = $urandom;
        case ($urandom_range(0, 3))
            0: for (int i = 0; i < kecat_pkg::MAX_CH; i++) ev.times[i] = $urandom;
            1: for (int i = 0; i < kecat_pkg::MAX_CH; i++)
                   ev.times[i] = $signed($urandom_range(0, 7)) - 4;
            2: for (int i = 0; i < kecat_pkg::MAX_CH; i++) ev.times[i] = edge_time();
            default:
                for (int i = 0; i < kecat_pkg::MAX_CH; i++)
                    ev.times[i] = base + $urandom_range(0, 3);
        endcase
        return ev;
    endfunction

    task automatic send_event(input t_event ev);
        int gap;
        gap = draw_gap(in_idle);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        drv_mask <= ev.mask;
        for (int i = 0; i < kecat_pkg::MAX_CH; i++) drv_time[i] <= ev.times[i];
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        rank_q.push_back(rank_select(ev.mask, ev.times, cur_rank));
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rank_q.size() != 0) @(negedge clk);
    endtask

    task automatic set_rank(input kecat_pkg::t_rank r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_rank = r;
    endtask

    task automatic send_direct(input kecat_pkg::t_mask mask, input t_time_vec times);
        t_event ev;
        ev.mask  = mask;
        ev.times = times;
        send_event(ev);
    endtask

    // receiver: hold off for a random gap, then take one transaction
    always begin : stall_gen
        int hold;
        @(negedge clk);
        hold = draw_gap(out_idle);
        if (hold > 0) begin
            out_stall <= 1'b1;
            repeat (hold) @(negedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(rst_n && out_valid));
    end

    always @(posedge clk) begin
        kecat_pkg::t_result exp_res;
        if (rst_n && out_valid && !out_stall) begin
            if (rank_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b time=%0d", $time, out_found,
                         out_time);
                errors++;
            end else begin
                exp_res = rank_q.pop_front();
                checked++;
                if (exp_res.found) found_cnt++;
                if (out_found !== exp_res.found) begin
                    $display("%0t: found mismatch expected=%0b actual=%0b", $time,
                             exp_res.found, out_found);
                    errors++;
                end
                if (out_time !== exp_res.sel_time) begin
                    $display("%0t: selected_time mismatch expected=%0d actual=%0d", $time,
                             exp_res.sel_time, out_time);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        t_time_vec ext;
        ext = {32'sh0001_0000, 32'sh8001_0000, 32'sh7FFF_0000, 32'sd1,
               -32'sd1, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF};
        in_idle  = IDLE_NONE;
        out_idle = IDLE_NONE;
        // reset rank is zero
        send_direct(8'h00, ext);
        send_direct(8'hFF, ext);
        send_direct(8'h01, ext);
        send_direct(8'h02, ext);
        set_rank(3'd7);
        send_direct(8'hFF, ext);
        send_direct(8'h7F, ext);
        send_direct(8'hFE, ext);
        send_direct(8'hFF, {8{-32'sd1}});
        set_rank(3'd3);
        send_direct(8'hFF, {{4{32'sh0001_0000}}, {4{32'sh0002_0000}}});
        send_direct(8'hF0, {{4{32'sh0001_0000}}, {4{32'sh0002_0000}}});
        send_direct(8'h07, {{4{32'sh0001_0000}}, {4{32'sh0002_0000}}});
        send_direct(8'hAA, {-32'sd6, 32'sd0, 32'sd9, 32'sd0, 32'sd9, 32'sd0, -32'sd6, 32'sd0});
        set_rank(3'd1);
        send_direct(8'h81, {-32'sd6, {6{32'sd0}}, -32'sd5});
        send_direct(8'h03, {{6{32'sd0}}, 32'sh8000_0000, 32'sh7FFF_FFFF});
        send_direct(8'h10, ext);
    endtask

    task automatic test_back_to_back();
        set_rank(kecat_pkg::t_rank'($urandom_range(0, 7)));
        in_idle  = IDLE_NONE;
        out_idle = IDLE_NONE;
        repeat (150) send_event(random_event());
    endtask

    task automatic test_rank_sweep();
        for (int r = 0; r < 8; r++) begin
            set_rank(kecat_pkg::t_rank'(r));
            for (int c = 0; c < 3; c++) begin
                in_idle  = draw_idle();
                out_idle = draw_idle();
                repeat (50) send_event(random_event());
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_back_to_back();
        test_rank_sweep();
        drain();
        out_idle = IDLE_NONE;
        repeat (4) @(posedge clk);
        $display("Sent %0d events over all ranks 0..7, %0d results checked, %0d found.",
                 sent, checked, found_cnt);
        $display("Directed extremes, ties and short masks, then random gaps and stalls.");
        if (errors == 0 && rank_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, rank_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d results still outstanding", rank_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== kth_earliest_active_channel_time.f =====
src/kecat_pkg.sv
src/kecat_select.sv
src/kth_earliest_active_channel_time.sv
tb/sv/tb_kth_earliest_active_channel_time.sv
